// ----- design/qn_pkg.sv -----
// Shared types and constants for the quaternion normalizer.
package qn_pkg;

	localparam int COMP_W = 16;               // input component width
	localparam int SUM_W  = 2 * COMP_W + 2;   // sum of squares, even width
	localparam int ROOT_W = COMP_W + 1;       // floor(sqrt(sum))
	localparam int REM_W  = COMP_W + 4;       // root remainder
	localparam int QUO_W  = 15;               // quotient bits, up to 16384
	localparam int NLANE  = 4;
	localparam logic [QUO_W-1:0] OUT_ONE = 15'd16384;

	typedef struct packed {
		logic signed [COMP_W-1:0] in_x;
		logic signed [COMP_W-1:0] in_y;
		logic signed [COMP_W-1:0] in_z;
		logic signed [COMP_W-1:0] in_w;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic signed [15:0] out_z;
		logic signed [15:0] out_w;
		logic               zero_magnitude;
	} out_word_t;

	// token moving down the square root row
	typedef struct packed {
		logic [SUM_W-1:0]              s;
		logic [REM_W-1:0]              r;
		logic [ROOT_W-1:0]             q;
		logic [NLANE-1:0][COMP_W-1:0]  mag;
		logic [NLANE-1:0]              neg;
	} sq_tok_t;

	// token moving down the divider row
	typedef struct packed {
		logic [ROOT_W-1:0]             m;
		logic [NLANE-1:0][ROOT_W:0]    rem;
		logic [NLANE-1:0][QUO_W-1:0]   quo;
		logic [NLANE-1:0]              nxt;
		logic [NLANE-1:0]              neg;
		logic                          zero;
	} dv_tok_t;

endpackage

// ----- design/quaternion_normalise_top.sv -----
// Top level of the quaternion normalizer: squares, root row, divider row.
//
//  channel | valid    | stall    | word
//  --------+----------+----------+--------------------
//  input   | up_valid | up_stall | up_word (in_word_t)
//  output  | dn_valid | dn_stall | dn_word (out_word_t)
//
// One word per cycle while the output is not stalled; registers in order:
// squares, sum, one cell per root bit, one cell per quotient bit, output.
// Reset clears every valid bit; payload registers are not reset.
// A stall on a valid output word freezes the whole row and is passed to the input.
module quaternion_normalise_top import qn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	output logic      up_stall,
	input  in_word_t  up_word,
	output logic      dn_valid,
	input  logic      dn_stall,
	output out_word_t dn_word
);

	logic                              en;
	logic [NLANE-1:0][COMP_W-1:0]      raw;
	logic [NLANE-1:0][COMP_W-1:0]      mag;
	logic [NLANE-1:0]                  neg;
	logic                              vld_s1;
	logic [NLANE-1:0][COMP_W-1:0]      mag_s1;
	logic [NLANE-1:0]                  neg_s1;
	logic [NLANE-1:0][2*COMP_W-1:0]    sq_s1;
	logic                              vld_s2;
	sq_tok_t                           tok_s2;
	sq_tok_t                           sq_tok [ROOT_W+1];
	logic                              sq_vld [ROOT_W+1];
	dv_tok_t                           dv_tok [QUO_W+1];
	logic                              dv_vld [QUO_W+1];
	logic [NLANE-1:0][15:0]            res;
	logic [QUO_W-1:0]                  qc;
	logic                              dn_valid_q;
	out_word_t                         dn_word_q;

	assign en       = !(dn_valid_q && dn_stall);
	assign up_stall = !en;

	// magnitude and sign of each component
	always_comb begin
		raw = {up_word.in_x, up_word.in_y, up_word.in_z, up_word.in_w};
		for (int l = 0; l < NLANE; l++) begin
			neg[l] = raw[l][COMP_W-1];
			mag[l] = neg[l] ? (~raw[l] + 1'b1) : raw[l];
		end
	end

	// stage 1: squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= up_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag;
			neg_s1 <= neg;
			for (int l = 0; l < NLANE; l++) begin
				sq_s1[l] <= mag[l] * mag[l];
			end
		end
	end

	// stage 2: exact sum of squares, start token of the root row
	always_ff @(posedge clk) begin
		if (en) begin
			tok_s2.s   <= SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1])
			            + SUM_W'(sq_s1[2]) + SUM_W'(sq_s1[3]);
			tok_s2.r   <= '0;
			tok_s2.q   <= '0;
			tok_s2.mag <= mag_s1;
			tok_s2.neg <= neg_s1;
		end
	end

	assign sq_tok[0] = tok_s2;
	assign sq_vld[0] = vld_s2;

	// root row
	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		qn_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (sq_vld[i]),
			.tok_in  (sq_tok[i]),
			.vld_out (sq_vld[i+1]),
			.tok_out (sq_tok[i+1])
		);
	end

	// start token of the divider row: dividend is mag * 2^14
	always_comb begin
		dv_tok[0].m    = sq_tok[ROOT_W].q;
		dv_tok[0].neg  = sq_tok[ROOT_W].neg;
		dv_tok[0].zero = (sq_tok[ROOT_W].q == '0);
		dv_tok[0].quo  = '0;
		for (int l = 0; l < NLANE; l++) begin
			dv_tok[0].rem[l] = {3'b000, sq_tok[ROOT_W].mag[l][COMP_W-1:1]};
			dv_tok[0].nxt[l] = sq_tok[ROOT_W].mag[l][0];
		end
	end
	assign dv_vld[0] = sq_vld[ROOT_W];

	// divider row
	for (genvar i = 0; i < QUO_W; i++) begin : g_div
		qn_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (dv_vld[i]),
			.tok_in  (dv_tok[i]),
			.vld_out (dv_vld[i+1]),
			.tok_out (dv_tok[i+1])
		);
	end

	// clamp, sign and zero case
	always_comb begin
		qc = '0;
		for (int l = 0; l < NLANE; l++) begin
			qc = (dv_tok[QUO_W].quo[l] > OUT_ONE) ? OUT_ONE : dv_tok[QUO_W].quo[l];
			if (dv_tok[QUO_W].zero) begin
				res[l] = '0;
			end else if (dv_tok[QUO_W].neg[l]) begin
				res[l] = 16'(~{1'b0, qc} + 1'b1);
			end else begin
				res[l] = {1'b0, qc};
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid_q <= 1'b0;
		end else if (en) begin
			dn_valid_q <= dv_vld[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn_word_q.out_x          <= res[3];
			dn_word_q.out_y          <= res[2];
			dn_word_q.out_z          <= res[1];
			dn_word_q.out_w          <= res[0];
			dn_word_q.zero_magnitude <= dv_tok[QUO_W].zero;
		end
	end

	assign dn_valid = dn_valid_q;
	assign dn_word  = dn_word_q;

`ifndef NO_ASSERTIONS
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid && dn_word.zero_magnitude |->
		dn_word.out_x == 16'sd0 && dn_word.out_y == 16'sd0 &&
		dn_word.out_z == 16'sd0 && dn_word.out_w == 16'sd0)
		else $error("zero magnitude word carries nonzero components");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid |->
		dn_word.out_x >= -16'sd16384 && dn_word.out_x <= 16'sd16384 &&
		dn_word.out_w >= -16'sd16384 && dn_word.out_w <= 16'sd16384)
		else $error("normalized component out of range");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid && !dn_word.zero_magnitude |->
		dn_word.out_x != 16'sd0 || dn_word.out_y != 16'sd0 ||
		dn_word.out_z != 16'sd0 || dn_word.out_w != 16'sd0)
		else $error("nonzero quaternion normalized to zero");
`endif

endmodule

// ----- design/qn_sqrt_cell.sv -----
// One digit cell of the square root row: settles one root bit.
module qn_sqrt_cell import qn_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    vld_in,
	input  sq_tok_t tok_in,
	output logic    vld_out,
	output sq_tok_t tok_out
);

	logic [REM_W-1:0] rr;
	logic [REM_W-1:0] trial;
	sq_tok_t          nxt;
	logic             vld_q;
	sq_tok_t          tok_q;

	// bring down two bits, try (root*4 + 1)
	always_comb begin
		nxt   = tok_in;
		rr    = {tok_in.r[REM_W-3:0], tok_in.s[SUM_W-1 -: 2]};
		trial = {{(REM_W-ROOT_W-2){1'b0}}, tok_in.q, 2'b01};
		nxt.s = {tok_in.s[SUM_W-3:0], 2'b00};
		if (rr >= trial) begin
			nxt.r = rr - trial;
			nxt.q = {tok_in.q[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.r = rr;
			nxt.q = {tok_in.q[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_q <= nxt;
		end
	end

	assign vld_out = vld_q;
	assign tok_out = tok_q;

endmodule

// ----- design/qn_div_cell.sv -----
// One digit cell of the divider row: one quotient bit for all four lanes.
module qn_div_cell import qn_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    vld_in,
	input  dv_tok_t tok_in,
	output logic    vld_out,
	output dv_tok_t tok_out
);

	logic [ROOT_W:0] rr   [NLANE];
	logic [ROOT_W:0] dvsr;
	dv_tok_t         nxt;
	logic            vld_q;
	dv_tok_t         tok_q;

	// restoring step per lane; the fresh dividend bit is used once
	always_comb begin
		nxt     = tok_in;
		dvsr    = {1'b0, tok_in.m};
		nxt.nxt = '0;
		for (int l = 0; l < NLANE; l++) begin
			rr[l] = {tok_in.rem[l][ROOT_W-1:0], tok_in.nxt[l]};
			if (rr[l] >= dvsr) begin
				nxt.rem[l] = rr[l] - dvsr;
				nxt.quo[l] = {tok_in.quo[l][QUO_W-2:0], 1'b1};
			end else begin
				nxt.rem[l] = rr[l];
				nxt.quo[l] = {tok_in.quo[l][QUO_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_q <= nxt;
		end
	end

	assign vld_out = vld_q;
	assign tok_out = tok_q;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the quaternion normalizer.
`timescale 1ns / 100ps
module tb;
	import qn_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      up_valid;
	logic      up_stall;
	in_word_t  up_word;
	logic      dn_valid;
	logic      dn_stall;
	out_word_t dn_word;

	in_word_t  pending_q[$];
	out_word_t unit_q[$];
	int        mismatches;
	bit        calm;

	quaternion_normalise_top u_top (
		.clk(clk), .arst_n(arst_n),
		.up_valid(up_valid), .up_stall(up_stall), .up_word(up_word),
		.dn_valid(dn_valid), .dn_stall(dn_stall), .dn_word(dn_word)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// integer square root of a sum of squares
	function automatic longint unsigned floor_root(longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// expected unit quaternion for one input word
	function automatic out_word_t normalize(in_word_t w);
		out_word_t o;
		longint unsigned mag[4], s, m, q;
		logic signed [COMP_W-1:0] c[4];
		logic [15:0] v[4];
		c = '{w.in_x, w.in_y, w.in_z, w.in_w};
		s = 0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = (c[i] < 0) ? longint'(-longint'(c[i])) : longint'(c[i]);
			s += mag[i] * mag[i];
		end
		o = '0;
		if (s == 0) begin
			o.zero_magnitude = 1'b1;
			return o;
		end
		m = floor_root(s);
		for (int i = 0; i < 4; i++) begin
			q = (mag[i] * 16384) / m;
			if (q > 16384) q = 16384;
			v[i] = (c[i] < 0) ? 16'(17'h10000 - q) : 16'(q);
		end
		o.out_x = v[0]; o.out_y = v[1]; o.out_z = v[2]; o.out_w = v[3];
		return o;
	endfunction

	function automatic in_word_t quat(int x, int y, int z, int w);
		in_word_t t;
		t.in_x = COMP_W'(x); t.in_y = COMP_W'(y);
		t.in_z = COMP_W'(z); t.in_w = COMP_W'(w);
		return t;
	endfunction

	function automatic logic [COMP_W-1:0] rnd_comp();
		case ($urandom_range(0, 5))
			0: return COMP_W'($urandom_range(0, 15) - 8);
			1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			default: return COMP_W'($urandom);
		endcase
	endfunction

	// driver: idles about 27% of cycles outside the calm stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_valid <= 1'b0;
			up_word  <= '0;
		end else if (!up_valid || !up_stall) begin
			if (up_valid) void'(pending_q.pop_front());
			if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 27)) begin
				up_valid <= 1'b1;
				up_word  <= pending_q[0];
			end else begin
				up_valid <= 1'b0;
			end
		end
	end

	// expected words are queued at acceptance
	always @(posedge clk) begin
		if (arst_n && up_valid && !up_stall) unit_q.push_back(normalize(up_word));
	end

	// monitor: random stalls and output check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_stall <= 1'b0;
		end else begin
			dn_stall <= !calm && ($urandom_range(0, 99) < 27);
			if (dn_valid && !dn_stall) begin
				if (unit_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected word %h", dn_word);
				end else begin
					out_word_t e;
					e = unit_q.pop_front();
					if (dn_word !== e) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h actual %h", e, dn_word);
					end
				end
			end
		end
	end

	initial begin
		int n;
		arst_n = 1'b0;
		mismatches = 0;
		calm = 1'b0;
		// directed: zero, extremes, single axes, signs
		pending_q.push_back(quat(0, 0, 0, 0));
		pending_q.push_back(quat(-32768, -32768, -32768, -32768));
		pending_q.push_back(quat(32767, 32767, 32767, 32767));
		pending_q.push_back(quat(-32768, 0, 0, 0));
		pending_q.push_back(quat(0, 32767, 0, 0));
		pending_q.push_back(quat(0, 0, -1, 0));
		pending_q.push_back(quat(0, 0, 0, 1));
		pending_q.push_back(quat(1, 1, 1, 1));
		pending_q.push_back(quat(-1, -1, -1, -1));
		pending_q.push_back(quat(4096, 0, 0, 0));
		pending_q.push_back(quat(0, 0, 0, -4096));
		pending_q.push_back(quat(2048, 2048, 2048, 2048));
		pending_q.push_back(quat(1, 32767, -32768, 3));
		pending_q.push_back(quat(-21845, 21845, 0, -1));
		pending_q.push_back(quat(0, 0, 0, 0));
		for (int i = 0; i < 1900; i++)
			pending_q.push_back(quat(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp()));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		n = 0;
		while (pending_q.size() > 0) begin
			@(posedge clk);
			n++;
			calm <= (n > 1000 && n < 1600);
		end
		while (unit_q.size() > 0 || up_valid) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && unit_q.size() == 0) begin
			$display("PASS quaternion_normalise_top");
		end else begin
			$display("FAIL quaternion_normalise_top");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL quaternion_normalise_top");
		$finish;
	end
endmodule
